@@ design/wat_pkg.sv @@
// Shared types and codes for the window address translator.
// No dependencies; the top, datapath and controller modules import this package.
package wat_pkg;

   localparam int ADDR_W = 64;

   // command codes
   localparam logic [1:0] CMD_WRITE = 2'd0;
   localparam logic [1:0] CMD_H2D   = 2'd1;
   localparam logic [1:0] CMD_D2H   = 2'd2;
   localparam logic [1:0] CMD_NONE  = 2'd3;

   // response status codes
   localparam logic [1:0] ST_OK       = 2'd0;
   localparam logic [1:0] ST_NO_MATCH = 2'd1;
   localparam logic [1:0] ST_BELOW    = 2'd2;

   // csr register indexes
   localparam logic [1:0] CSR_HOST_BASE    = 2'd0;
   localparam logic [1:0] CSR_BAR_OFFSET   = 2'd1;
   localparam logic [1:0] CSR_APPLY_OFFSET = 2'd2;
   localparam logic [1:0] CSR_BYPASS_D2H   = 2'd3;

   // result register load selects
   typedef logic [2:0] res_sel_type;
   localparam res_sel_type RES_ZERO    = 3'd0;
   localparam res_sel_type RES_PASS    = 3'd1;
   localparam res_sel_type RES_BELOW   = 3'd2;
   localparam res_sel_type RES_MISS    = 3'd3;
   localparam res_sel_type RES_HIT     = 3'd4;
   localparam res_sel_type RES_ADDHOST = 3'd5;

   typedef struct packed {
      logic [1:0]        command;
      logic [ADDR_W-1:0] address;
      logic [2:0]        window_index;
      logic              window_valid;
      logic [ADDR_W-1:0] window_bar_base;
      logic [ADDR_W-1:0] window_length;
      logic [ADDR_W-1:0] window_target_base;
   } req_payload_type;

   typedef struct packed {
      logic [ADDR_W-1:0] translated_address;
      logic [1:0]        status;
   } rsp_payload_type;

   typedef struct packed {
      logic        accept;
      logic        prep;
      logic        scanning;
      logic        res_set;
      res_sel_type res_sel;
      logic        load_out;
   } dp_cmd_type;

   typedef struct packed {
      logic [1:0] command;
      logic       below;
      logic       bypass;
      logic       hit;
      logic       miss_done;
   } dp_status_type;

endpackage

@@ design/wat_stream_if.sv @@
// Valid/ready stream interface used by the request and response channels.
// Payload type is a parameter; the payload structs come from wat_pkg.
interface wat_stream_if #(parameter type payload_type = logic);
   logic        valid;
   logic        ready;
   payload_type payload;

   modport source (output valid, output payload, input ready);
   modport sink   (input valid, input payload, output ready);
endinterface

@@ design/window_address_translator_top.sv @@
// Window address translator. One transaction at a time; a window write, an unused
// command or a bypassed device-to-host lookup has its result set in prep. A translation
// scans the table one window per cycle through a 3-stage pipe; the first hit gives the
// result (plus the host base for device-to-host), a miss is flagged at the last window.
// The next request is taken the cycle after the response is registered, even if the
// response is still held. Synchronous reset clears csrs, window valid bits and control.
module window_address_translator_top #(
   parameter int WINDOWS = 8
) (
   input  logic         clock,
   input  logic         reset,
   wat_stream_if.sink   req_if,
   wat_stream_if.source rsp_if,
   input  logic         csr_write_enable,
   input  logic [1:0]   csr_index,
   input  logic [63:0]  csr_write_data
);
   import wat_pkg::*;

   dp_cmd_type      ctrl_cmd;
   dp_status_type   dp_status;
   rsp_payload_type rsp_payload;

   wat_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_if.valid),
      .req_ready (req_if.ready),
      .rsp_valid (rsp_if.valid),
      .rsp_ready (rsp_if.ready),
      .status    (dp_status),
      .cmd       (ctrl_cmd)
   );

   wat_dp #(.WINDOWS(WINDOWS)) u_dp (
      .clock            (clock),
      .reset            (reset),
      .req_payload      (req_if.payload),
      .cmd              (ctrl_cmd),
      .status           (dp_status),
      .csr_write_enable (csr_write_enable),
      .csr_index        (csr_index),
      .csr_write_data   (csr_write_data),
      .rsp_payload      (rsp_payload)
   );

   assign rsp_if.payload = rsp_payload;

   // an error response never carries an address
   a_err_zero_addr: assert property (@(posedge clock) disable iff (reset)
      rsp_if.valid && (rsp_if.payload.status != ST_OK) |->
         (rsp_if.payload.translated_address == '0))
      else $error("error response with nonzero address");

   // one transaction in flight: no accept right after an accept
   a_single_txn: assert property (@(posedge clock) disable iff (reset)
      req_if.valid && req_if.ready |=> !req_if.ready)
      else $error("request accepted while busy");

   // a hit result is only taken when the scan pipe reports a match
   a_hit_source: assert property (@(posedge clock) disable iff (reset)
      ctrl_cmd.res_set && (ctrl_cmd.res_sel == RES_HIT) |->
         dp_status.hit && ctrl_cmd.scanning)
      else $error("hit result without scan match");

endmodule

@@ design/wat_dp.sv @@
// Datapath: csr registers, window table, pipelined window scan and result registers.
// Depends on wat_pkg; driven by wat_ctrl through dp_cmd_type / dp_status_type.
module wat_dp #(
   parameter int WINDOWS = 8
) (
   input  logic                     clock,
   input  logic                     reset,
   input  wat_pkg::req_payload_type req_payload,
   input  wat_pkg::dp_cmd_type      cmd,
   output wat_pkg::dp_status_type   status,
   input  logic                     csr_write_enable,
   input  logic [1:0]               csr_index,
   input  logic [63:0]              csr_write_data,
   output wat_pkg::rsp_payload_type rsp_payload
);
   import wat_pkg::*;

   localparam int IDX_W = (WINDOWS > 1) ? $clog2(WINDOWS) : 1;
   localparam logic [IDX_W-1:0] LAST_IDX = IDX_W'(WINDOWS - 1);

   // configuration
   logic [ADDR_W-1:0] host_ff, offset_ff;
   logic              apply_ff, bypass_ff;

   // current transaction
   logic [1:0]        cmd_ff;
   logic [ADDR_W-1:0] addr_ff, key_ff;
   logic              below_ff;
   logic              is_d2h;

   // window table
   logic [WINDOWS-1:0] valid_ff;
   logic [ADDR_W-1:0]  bar_mem  [WINDOWS];
   logic [ADDR_W-1:0]  size_mem [WINDOWS];
   logic [ADDR_W-1:0]  tgt_mem  [WINDOWS];
   logic               wr_en;
   logic [IDX_W-1:0]   wr_idx;

   // scan control
   logic [IDX_W-1:0] scan_idx_ff;
   logic             issuing_ff, issue;

   // stage 1: table read
   logic              s1_vld_ff, s1_last_ff, s1_ent_ff;
   logic [ADDR_W-1:0] rd_bar_ff, rd_size_ff, rd_tgt_ff;
   // stage 2: effective bases
   logic              s2_vld_ff, s2_last_ff, s2_ent_ff;
   logic [ADDR_W-1:0] s2_base_ff, s2_addend_ff, s2_size_ff;
   logic [ADDR_W-1:0] eff_bar;
   // stage 3: range check
   logic              s3_vld_ff, s3_last_ff, s3_match_ff;
   logic [ADDR_W-1:0] s3_diff_ff, s3_addend_ff;
   logic [ADDR_W:0]   sum_ext, diff_ext;
   logic              match;

   // results
   logic [ADDR_W-1:0] res_ff, out_addr_ff;
   logic [1:0]        st_ff, out_st_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         host_ff   <= '0;
         offset_ff <= '0;
         apply_ff  <= 1'b0;
         bypass_ff <= 1'b0;
      end else if (csr_write_enable) begin
         case (csr_index)
            CSR_HOST_BASE:    host_ff   <= csr_write_data;
            CSR_BAR_OFFSET:   offset_ff <= csr_write_data;
            CSR_APPLY_OFFSET: apply_ff  <= csr_write_data[0];
            CSR_BYPASS_D2H:   bypass_ff <= csr_write_data[0];
            default: ;
         endcase
      end
   end

   assign wr_en  = cmd.accept && (req_payload.command == CMD_WRITE) &&
                   ({29'd0, req_payload.window_index} < 32'(WINDOWS));
   assign wr_idx = IDX_W'(req_payload.window_index);
   assign is_d2h = (cmd_ff == CMD_D2H);

   always_ff @(posedge clock) begin
      if (cmd.accept) begin
         cmd_ff  <= req_payload.command;
         addr_ff <= req_payload.address;
      end
      if (cmd.prep) begin
         key_ff   <= (cmd_ff == CMD_H2D) ? addr_ff - host_ff : addr_ff;
         below_ff <= addr_ff < host_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= '0;
      end else if (wr_en) begin
         valid_ff[wr_idx] <= req_payload.window_valid;
      end
   end

   always_ff @(posedge clock) begin
      if (wr_en) begin
         bar_mem[wr_idx]  <= req_payload.window_bar_base;
         size_mem[wr_idx] <= req_payload.window_length;
         tgt_mem[wr_idx]  <= req_payload.window_target_base;
      end
      rd_bar_ff  <= bar_mem[scan_idx_ff];
      rd_size_ff <= size_mem[scan_idx_ff];
      rd_tgt_ff  <= tgt_mem[scan_idx_ff];
   end

   assign issue = cmd.scanning && issuing_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         scan_idx_ff <= '0;
         issuing_ff  <= 1'b0;
         s1_vld_ff   <= 1'b0;
         s2_vld_ff   <= 1'b0;
         s3_vld_ff   <= 1'b0;
      end else if (cmd.prep) begin
         scan_idx_ff <= '0;
         issuing_ff  <= 1'b1;
         s1_vld_ff   <= 1'b0;
         s2_vld_ff   <= 1'b0;
         s3_vld_ff   <= 1'b0;
      end else begin
         if (issue) begin
            if (scan_idx_ff == LAST_IDX) begin
               issuing_ff <= 1'b0;
            end else begin
               scan_idx_ff <= scan_idx_ff + 1'b1;
            end
         end
         s1_vld_ff <= issue;
         s2_vld_ff <= s1_vld_ff;
         s3_vld_ff <= s2_vld_ff;
      end
   end

   assign eff_bar  = rd_bar_ff - (apply_ff ? offset_ff : '0);
   // window holds key when base <= key and base + size does not wrap and exceeds key
   assign sum_ext  = {1'b0, s2_base_ff} + {1'b0, s2_size_ff};
   assign diff_ext = {1'b0, key_ff} - {1'b0, s2_base_ff};
   assign match    = s2_ent_ff && !diff_ext[ADDR_W] && !sum_ext[ADDR_W] &&
                     (diff_ext[ADDR_W-1:0] < s2_size_ff);

   always_ff @(posedge clock) begin
      s1_last_ff   <= (scan_idx_ff == LAST_IDX);
      s1_ent_ff    <= valid_ff[scan_idx_ff];
      s2_last_ff   <= s1_last_ff;
      s2_ent_ff    <= s1_ent_ff;
      s2_size_ff   <= rd_size_ff;
      s2_base_ff   <= is_d2h ? rd_tgt_ff : eff_bar;
      s2_addend_ff <= is_d2h ? eff_bar : rd_tgt_ff;
      s3_last_ff   <= s2_last_ff;
      s3_match_ff  <= match;
      s3_diff_ff   <= diff_ext[ADDR_W-1:0];
      s3_addend_ff <= s2_addend_ff;
   end

   always_ff @(posedge clock) begin
      if (cmd.res_set) begin
         case (cmd.res_sel)
            RES_PASS: begin
               res_ff <= addr_ff;
               st_ff  <= ST_OK;
            end
            RES_BELOW: begin
               res_ff <= '0;
               st_ff  <= ST_BELOW;
            end
            RES_MISS: begin
               res_ff <= '0;
               st_ff  <= ST_NO_MATCH;
            end
            RES_HIT: begin
               res_ff <= s3_diff_ff + s3_addend_ff;
               st_ff  <= ST_OK;
            end
            RES_ADDHOST: begin
               res_ff <= res_ff + host_ff;
               st_ff  <= ST_OK;
            end
            default: begin
               res_ff <= '0;
               st_ff  <= ST_OK;
            end
         endcase
      end
      if (cmd.load_out) begin
         out_addr_ff <= res_ff;
         out_st_ff   <= st_ff;
      end
   end

   assign status.command   = cmd_ff;
   assign status.below     = below_ff;
   assign status.bypass    = bypass_ff;
   assign status.hit       = s3_vld_ff && s3_match_ff;
   assign status.miss_done = s3_vld_ff && s3_last_ff && !s3_match_ff;

   assign rsp_payload.translated_address = out_addr_ff;
   assign rsp_payload.status             = out_st_ff;

endmodule

@@ design/wat_ctrl.sv @@
// Controller state machine: sequences accept, prep, window scan, host-base add and response.
// Depends on wat_pkg; commands wat_dp and owns the response valid flag.
module wat_ctrl (
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   req_valid,
   output logic                   req_ready,
   output logic                   rsp_valid,
   input  logic                   rsp_ready,
   input  wat_pkg::dp_status_type status,
   output wat_pkg::dp_cmd_type    cmd
);
   import wat_pkg::*;

   localparam logic [2:0] S_IDLE    = 3'd0;
   localparam logic [2:0] S_PREP    = 3'd1;
   localparam logic [2:0] S_SCAN    = 3'd2;
   localparam logic [2:0] S_ADDHOST = 3'd3;
   localparam logic [2:0] S_FINISH  = 3'd4;

   logic [2:0] state_ff, state_in;
   logic       out_valid_ff, out_valid_in;
   logic       accept;

   assign req_ready = (state_ff == S_IDLE);
   assign accept    = req_valid && req_ready;

   always_comb begin
      cmd      = '0;
      state_in = state_ff;
      case (state_ff)
         S_IDLE: begin
            cmd.accept = accept;
            if (accept) state_in = S_PREP;
         end
         S_PREP: begin
            cmd.prep = 1'b1;
            case (status.command)
               CMD_H2D: state_in = S_SCAN;
               CMD_D2H: begin
                  if (status.bypass) begin
                     cmd.res_set = 1'b1;
                     cmd.res_sel = RES_PASS;
                     state_in    = S_FINISH;
                  end else begin
                     state_in = S_SCAN;
                  end
               end
               default: begin
                  cmd.res_set = 1'b1;
                  cmd.res_sel = RES_ZERO;
                  state_in    = S_FINISH;
               end
            endcase
         end
         S_SCAN: begin
            cmd.scanning = 1'b1;
            if ((status.command == CMD_H2D) && status.below) begin
               cmd.res_set = 1'b1;
               cmd.res_sel = RES_BELOW;
               state_in    = S_FINISH;
            end else if (status.hit) begin
               // first hit wins; later entries still in flight are dropped
               cmd.res_set = 1'b1;
               cmd.res_sel = RES_HIT;
               state_in    = (status.command == CMD_D2H) ? S_ADDHOST : S_FINISH;
            end else if (status.miss_done) begin
               cmd.res_set = 1'b1;
               cmd.res_sel = RES_MISS;
               state_in    = S_FINISH;
            end
         end
         S_ADDHOST: begin
            cmd.res_set = 1'b1;
            cmd.res_sel = RES_ADDHOST;
            state_in    = S_FINISH;
         end
         S_FINISH: begin
            if (!out_valid_ff || rsp_ready) begin
               cmd.load_out = 1'b1;
               state_in     = S_IDLE;
            end
         end
         default: state_in = S_IDLE;
      endcase
   end

   always_comb begin
      if (cmd.load_out) out_valid_in = 1'b1;
      else if (rsp_ready) out_valid_in = 1'b0;
      else out_valid_in = out_valid_ff;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         out_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         out_valid_ff <= out_valid_in;
      end
   end

   assign rsp_valid = out_valid_ff;

endmodule

@@ test/window_address_translator_top_test.sv @@
// Self-checking testbench for window_address_translator_top.
// Depends on wat_pkg and wat_stream_if; holds its own window table and csr copy,
// and checks every response in order against it or a directed expected result.
`timescale 1ns / 1ps

module window_address_translator_top_test;
   import wat_pkg::*;

   localparam int          WINDOWS       = 8;
   localparam int          LIMIT_CYCLES  = 400000;
   localparam int          PHASES        = 12;
   localparam int          PHASE_ITEMS   = 128;
   localparam int          HOLD_CYCLES   = 300;
   localparam int          SETTLE_CYCLES = 4;
   localparam logic [63:0] ALL_ONES      = '1;

   typedef struct {
      bit              is_csr;
      logic [1:0]      csr_sel;
      logic [63:0]     csr_value;
      req_payload_type txn;
      bit              typed;
      rsp_payload_type want;
   } directed_row_type;

   logic        clock = 1'b0;
   logic        reset = 1'b1;
   logic        csr_write_enable;
   logic [1:0]  csr_index;
   logic [63:0] csr_write_data;

   wat_stream_if #(.payload_type(req_payload_type)) req_chan ();
   wat_stream_if #(.payload_type(rsp_payload_type)) rsp_chan ();

   window_address_translator_top #(.WINDOWS(WINDOWS)) i_dut (
      .clock            (clock),
      .reset            (reset),
      .req_if           (req_chan),
      .rsp_if           (rsp_chan),
      .csr_write_enable (csr_write_enable),
      .csr_index        (csr_index),
      .csr_write_data   (csr_write_data)
   );

   always #5 clock = ~clock;

   // translator state as the block should hold it
   logic [63:0] cfg_host_base;
   logic [63:0] cfg_bar_offset;
   logic        cfg_apply_offset;
   logic        cfg_bypass_d2h;
   logic        win_valid  [WINDOWS];
   logic [63:0] win_bar    [WINDOWS];
   logic [63:0] win_size   [WINDOWS];
   logic [63:0] win_target [WINDOWS];

   rsp_payload_type translations_due[$];

   int error_count;
   int items_sent;
   int responses_seen;
   int ok_count;
   int miss_count;
   int below_count;
   int burst_left;
   int hold_requests;
   int cycle_count;

   always @(posedge clock) cycle_count <= cycle_count + 1;

   initial begin
      wait (cycle_count >= LIMIT_CYCLES);
      $display("%0t: timeout, %0d translations still outstanding", $time,
               translations_due.size());
      $display("status: fail");
      $finish;
   end

   function automatic logic [63:0] eff_bar(int i);
      return cfg_apply_offset ? win_bar[i] - cfg_bar_offset : win_bar[i];
   endfunction

   // a window whose end wraps past 2^64 holds nothing
   function automatic bit window_holds(logic [63:0] base, logic [63:0] size,
                                       logic [63:0] addr);
      logic [63:0] limit;
      limit = base + size;
      return (base <= addr) && (limit > addr);
   endfunction

   function automatic rsp_payload_type compute_translation(req_payload_type t);
      rsp_payload_type r;
      logic [63:0]     off;
      logic [63:0]     b;
      bit              found;
      r     = '0;
      found = 0;
      case (t.command)
         CMD_WRITE: begin
            win_valid[t.window_index]  = t.window_valid;
            win_bar[t.window_index]    = t.window_bar_base;
            win_size[t.window_index]   = t.window_length;
            win_target[t.window_index] = t.window_target_base;
         end
         CMD_H2D: begin
            if (t.address < cfg_host_base) begin
               r.status = ST_BELOW;
            end else begin
               off      = t.address - cfg_host_base;
               r.status = ST_NO_MATCH;
               for (int i = 0; i < WINDOWS; i++) begin
                  b = eff_bar(i);
                  if (!found && win_valid[i] && window_holds(b, win_size[i], off)) begin
                     r.translated_address = off - b + win_target[i];
                     r.status             = ST_OK;
                     found                = 1;
                  end
               end
            end
         end
         CMD_D2H: begin
            if (cfg_bypass_d2h) begin
               r.translated_address = t.address;
            end else begin
               r.status = ST_NO_MATCH;
               for (int i = 0; i < WINDOWS; i++) begin
                  if (!found && win_valid[i]
                      && window_holds(win_target[i], win_size[i], t.address)) begin
                     r.translated_address = t.address - win_target[i] + eff_bar(i)
                                            + cfg_host_base;
                     r.status             = ST_OK;
                     found                = 1;
                  end
               end
            end
         end
         default: ;
      endcase
      return r;
   endfunction

   function automatic logic [63:0] rand64();
      return {$urandom, $urandom};
   endfunction

   // mix of extremes, small values and full-width values
   function automatic logic [63:0] pick64();
      case ($urandom_range(0, 7))
         0:       return '0;
         1:       return ALL_ONES;
         2, 3:    return rand64();
         4:       return {32'h0, $urandom};
         default: return rand64() >> $urandom_range(0, 60);
      endcase
   endfunction

   function automatic logic [63:0] pick_length();
      case ($urandom_range(0, 9))
         0:       return '0;
         1:       return ALL_ONES;
         2:       return rand64();
         default: return 64'($urandom_range(1, 65536));
      endcase
   endfunction

   function automatic req_payload_type random_request();
      req_payload_type t;
      t.command            = 2'($urandom_range(0, 3));
      t.address            = rand64();
      t.window_index       = 3'($urandom_range(0, 7));
      t.window_valid       = 1'($urandom_range(0, 1));
      t.window_bar_base    = rand64();
      t.window_length      = rand64();
      t.window_target_base = rand64();
      return t;
   endfunction

   function automatic req_payload_type random_window_write();
      req_payload_type t;
      t                    = random_request();
      t.command            = CMD_WRITE;
      t.window_valid       = ($urandom_range(0, 4) != 0);
      t.window_bar_base    = pick64();
      t.window_length      = pick_length();
      t.window_target_base = pick64();
      return t;
   endfunction

   // address inside window i, on the host side or the device side;
   // now and then one past the end, to probe the upper bound
   function automatic logic [63:0] address_in_window(int i, bit host_side);
      logic [63:0] off;
      case ($urandom_range(0, 9))
         0:       off = '0;
         1:       off = win_size[i] - 1;
         2:       off = win_size[i];
         default: off = (win_size[i] == 0) ? '0 : rand64() % win_size[i];
      endcase
      return host_side ? eff_bar(i) + off + cfg_host_base : win_target[i] + off;
   endfunction

   function automatic directed_row_type write_row(logic [2:0] idx, logic vld,
                                                  logic [63:0] bar, logic [63:0] len,
                                                  logic [63:0] tgt);
      directed_row_type row;
      row                        = '{default: '0};
      row.txn.command            = CMD_WRITE;
      row.txn.window_index       = idx;
      row.txn.window_valid       = vld;
      row.txn.window_bar_base    = bar;
      row.txn.window_length      = len;
      row.txn.window_target_base = tgt;
      row.typed                  = 1;
      row.want.status            = ST_OK;
      return row;
   endfunction

   function automatic directed_row_type lookup_row(logic [1:0] cmd, logic [63:0] addr,
                                                   bit typed, logic [63:0] want_addr,
                                                   logic [1:0] want_status);
      directed_row_type row;
      row                         = '{default: '0};
      row.txn.command             = cmd;
      row.txn.address             = addr;
      row.typed                   = typed;
      row.want.translated_address = want_addr;
      row.want.status             = want_status;
      return row;
   endfunction

   function automatic directed_row_type csr_row(logic [1:0] sel, logic [63:0] value);
      directed_row_type row;
      row           = '{default: '0};
      row.is_csr    = 1;
      row.csr_sel   = sel;
      row.csr_value = value;
      return row;
   endfunction

   // offer one transaction; returns at the edge that accepted it, or after a random idle gap once a burst is used up
   task automatic offer(req_payload_type t, bit typed, rsp_payload_type want);
      rsp_payload_type model_rsp;
      req_chan.valid   <= 1'b1;
      req_chan.payload <= t;
      do @(posedge clock); while (req_chan.ready !== 1'b1);
      model_rsp = compute_translation(t);
      translations_due.push_back(typed ? want : model_rsp);
      items_sent++;
      if (burst_left > 0) begin
         burst_left--;
      end else begin
         req_chan.valid <= 1'b0;
         repeat ($urandom_range(1, 10)) @(posedge clock);
         burst_left = ($urandom_range(0, 7) == 0) ? $urandom_range(60, 150)
                                                   : $urandom_range(0, 12);
      end
   endtask

   // drain the block before touching the csrs
   task automatic settle();
      req_chan.valid <= 1'b0;
      while (translations_due.size() != 0) @(posedge clock);
      repeat (SETTLE_CYCLES) @(posedge clock);
   endtask

   // leaves the write enable high; caller drops it after the last write
   task automatic write_register(logic [1:0] sel, logic [63:0] value);
      csr_write_enable <= 1'b1;
      csr_index        <= sel;
      csr_write_data   <= value;
      case (sel)
         CSR_HOST_BASE:    cfg_host_base    = value;
         CSR_BAR_OFFSET:   cfg_bar_offset   = value;
         CSR_APPLY_OFFSET: cfg_apply_offset = value[0];
         CSR_BYPASS_D2H:   cfg_bypass_d2h   = value[0];
         default: ;
      endcase
      @(posedge clock);
   endtask

   task automatic program_settings(logic [63:0] host, logic [63:0] offset,
                                   logic apply, logic bypass);
      settle();
      write_register(CSR_HOST_BASE, host);
      write_register(CSR_BAR_OFFSET, offset);
      write_register(CSR_APPLY_OFFSET, {63'(rand64()), apply});
      write_register(CSR_BYPASS_D2H, {63'(rand64()), bypass});
      csr_write_enable <= 1'b0;
   endtask

   // response side: checks in order, stalls on its own pattern
   initial begin
      int ready_mode;
      int mode_left;
      int hold_left;
      int holds_served;
      rsp_payload_type got;
      rsp_payload_type want;
      ready_mode     = 0;
      mode_left      = 0;
      hold_left      = 0;
      holds_served   = 0;
      rsp_chan.ready <= 1'b0;
      forever begin
         @(posedge clock);
         if (!reset && rsp_chan.valid === 1'b1 && rsp_chan.ready === 1'b1) begin
            got = rsp_chan.payload;
            responses_seen++;
            case (got.status)
               ST_OK:       ok_count++;
               ST_NO_MATCH: miss_count++;
               ST_BELOW:    below_count++;
               default: ;
            endcase
            if (translations_due.size() == 0) begin
               $display("%0t: unexpected response, expected none, got address %h status %0d",
                        $time, got.translated_address, got.status);
               error_count++;
            end else begin
               want = translations_due.pop_front();
               if (got.translated_address !== want.translated_address) begin
                  $display("%0t: translated_address expected %h got %h", $time,
                           want.translated_address, got.translated_address);
                  error_count++;
               end
               if (got.status !== want.status) begin
                  $display("%0t: status expected %0d got %0d", $time,
                           want.status, got.status);
                  error_count++;
               end
            end
         end
         if (holds_served != hold_requests) begin
            holds_served = hold_requests;
            hold_left    = HOLD_CYCLES;
         end
         if (mode_left == 0) begin
            ready_mode = $urandom_range(0, 3);
            mode_left  = $urandom_range(20, 200);
         end else begin
            mode_left--;
         end
         if (hold_left > 0) begin
            hold_left--;
            rsp_chan.ready <= 1'b0;
         end else begin
            case (ready_mode)
               0:       rsp_chan.ready <= 1'b1;
               1:       rsp_chan.ready <= 1'($urandom_range(0, 1));
               2:       rsp_chan.ready <= (mode_left % 4 != 0);
               default: rsp_chan.ready <= ($urandom_range(0, 3) == 0);
            endcase
         end
      end
   end

   initial begin
      directed_row_type rows[$];
      req_payload_type  t;
      int               live[$];
      int               k;
      logic [63:0]      host;

      req_chan.valid   <= 1'b0;
      req_chan.payload <= '0;
      csr_write_enable <= 1'b0;
      csr_index        <= CSR_HOST_BASE;
      csr_write_data   <= '0;
      cfg_host_base    = '0;
      cfg_bar_offset   = '0;
      cfg_apply_offset = 1'b0;
      cfg_bypass_d2h   = 1'b0;
      for (int i = 0; i < WINDOWS; i++) begin
         win_valid[i]  = 1'b0;
         win_bar[i]    = '0;
         win_size[i]   = '0;
         win_target[i] = '0;
      end
      burst_left = 0;

      repeat (4) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // empty table and reset csrs first
      rows.push_back(lookup_row(CMD_H2D, '0, 1, '0, ST_NO_MATCH));
      rows.push_back(lookup_row(CMD_D2H, ALL_ONES, 1, '0, ST_NO_MATCH));
      rows.push_back(lookup_row(CMD_NONE, ALL_ONES, 1, '0, ST_OK));
      rows.push_back(write_row(3'd0, 1'b1, 64'h1000, 64'h1000, 64'h8000_0000));
      rows.push_back(lookup_row(CMD_H2D, 64'h1000, 1, 64'h8000_0000, ST_OK));
      rows.push_back(lookup_row(CMD_H2D, 64'h1fff, 1, 64'h8000_0fff, ST_OK));
      rows.push_back(lookup_row(CMD_H2D, 64'h2000, 1, '0, ST_NO_MATCH));
      rows.push_back(lookup_row(CMD_D2H, 64'h8000_0fff, 1, 64'h1fff, ST_OK));
      // catch-all window at the last slot; lower slots must win
      rows.push_back(write_row(3'd7, 1'b1, '0, ALL_ONES, '0));
      rows.push_back(lookup_row(CMD_H2D, 64'h1800, 0, '0, ST_OK));
      rows.push_back(lookup_row(CMD_H2D, ALL_ONES, 0, '0, ST_OK));
      // window whose end wraps past the top never matches
      rows.push_back(write_row(3'd3, 1'b1, 64'hffff_ffff_ffff_f000, 64'h2000, 64'h10));
      rows.push_back(lookup_row(CMD_H2D, 64'hffff_ffff_ffff_f800, 0, '0, ST_OK));
      rows.push_back(write_row(3'd5, 1'b0, ALL_ONES, ALL_ONES, ALL_ONES));
      rows.push_back(write_row(3'd1, 1'b1, 64'h5000, '0, 64'h9000));
      rows.push_back(lookup_row(CMD_H2D, 64'h5000, 0, '0, ST_OK));
      rows.push_back(csr_row(CSR_HOST_BASE, 64'h1_0000));
      rows.push_back(lookup_row(CMD_H2D, 64'hffff, 1, '0, ST_BELOW));
      rows.push_back(csr_row(CSR_BYPASS_D2H, 64'h1));
      rows.push_back(lookup_row(CMD_D2H, 64'hdead_beef_0000_0001, 1,
                                64'hdead_beef_0000_0001, ST_OK));
      rows.push_back(csr_row(CSR_BAR_OFFSET, 64'h1000));
      rows.push_back(csr_row(CSR_APPLY_OFFSET, 64'h1));
      rows.push_back(write_row(3'd7, 1'b0, '0, '0, '0));
      rows.push_back(write_row(3'd2, 1'b1, 64'h3000, 64'h100, 64'h40));
      rows.push_back(lookup_row(CMD_H2D, 64'h1_2010, 0, '0, ST_OK));
      rows.push_back(lookup_row(CMD_D2H, 64'h40, 0, '0, ST_OK));
      rows.push_back(csr_row(CSR_BYPASS_D2H, 64'h0));
      rows.push_back(lookup_row(CMD_D2H, 64'h40, 0, '0, ST_OK));

      foreach (rows[r]) begin
         if (rows[r].is_csr) begin
            if (r == 0 || !rows[r-1].is_csr) settle();
            write_register(rows[r].csr_sel, rows[r].csr_value);
            if (r == rows.size() - 1 || !rows[r+1].is_csr) csr_write_enable <= 1'b0;
         end else begin
            offer(rows[r].txn, rows[r].typed, rows[r].want);
         end
      end

      for (int p = 0; p < PHASES; p++) begin
         case (p)
            0: program_settings('0, '0, 1'b0, 1'b0);
            1: program_settings(ALL_ONES, ALL_ONES, 1'b1, 1'b1);
            2: program_settings('0, ALL_ONES, 1'b1, 1'b0);
            default: begin
               host = ($urandom_range(0, 3) == 0) ? pick64()
                                                  : rand64() >> $urandom_range(20, 63);
               program_settings(host, pick64(), 1'($urandom_range(0, 1)),
                                ($urandom_range(0, 3) == 0));
            end
         endcase
         for (int w = 0; w < WINDOWS; w++) begin
            t              = random_window_write();
            t.window_index = 3'(w);
            offer(t, 0, '0);
         end
         if (p == 2 || p == 7) hold_requests++;
         for (int n = 0; n < PHASE_ITEMS; n++) begin
            if (n == PHASE_ITEMS / 2 && p % 3 == 1) settle();
            k = $urandom_range(0, 99);
            if (k < 10) begin
               t = random_window_write();
            end else if (k < 75) begin
               t         = random_request();
               t.command = $urandom_range(0, 1) ? CMD_H2D : CMD_D2H;
               live.delete();
               for (int i = 0; i < WINDOWS; i++) if (win_valid[i]) live.push_back(i);
               if (live.size() != 0)
                  t.address = address_in_window(live[$urandom_range(0, live.size() - 1)],
                                                t.command == CMD_H2D);
            end else if (k < 85) begin
               t = random_request();
            end else if (k < 92) begin
               t         = random_request();
               t.command = CMD_H2D;
               t.address = (cfg_host_base == 0) ? '0 : rand64() % cfg_host_base;
            end else begin
               t         = random_request();
               t.command = CMD_NONE;
            end
            offer(t, 0, '0);
         end
      end

      req_chan.valid <= 1'b0;
      while (translations_due.size() != 0) @(posedge clock);
      repeat (20) @(posedge clock);

      $display("covered %0d transactions over %0d csr settings: %0d ok, %0d no match, %0d below base",
               items_sent, PHASES + 1, ok_count, miss_count, below_count);
      $display("%0d responses checked, %0d mismatches", responses_seen, error_count);
      if (error_count == 0) begin
         $display("status: pass");
      end else begin
         $display("status: fail");
      end
      $finish;
   end

endmodule
